// ----- hw/rtl/speed_sensor_average_and_scale_core_assert.svh -----
// Assertion macros for the speed sensor core.
// Each macro checks a property at every rising clock edge outside of reset.
`ifndef SPEED_SENSOR_AVERAGE_AND_SCALE_CORE_ASSERT_SVH
`define SPEED_SENSOR_AVERAGE_AND_SCALE_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define SSAS_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define SSAS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define SSAS_ASSERT_IMPLY(label, ante, cons, msg)
`define SSAS_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ----- hw/rtl/ssas_pkg.sv -----
`default_nettype none

package ssas_pkg;

   // Field widths.
   localparam int ADC_W    = 16;
   localparam int SAMPLE_W = 10;
   localparam int RAW_W    = 7;
   localparam int CAL_W    = 8;
   localparam int SCALE_W  = 16;

   // Averaging window; the depth is a power of two so the mean is a shift.
   localparam int AVG_LOG2 = 4;
   localparam int AVG_DEPTH = 1 << AVG_LOG2;
   localparam int SUM_W = SAMPLE_W + AVG_LOG2;

   // Front datapath widths.
   localparam int GAIN_W  = 11;
   localparam int PROD1_W = SAMPLE_W + GAIN_W;
   localparam int V_W     = PROD1_W - 10;
   localparam int K_W     = 15;
   localparam int PROD2_W = V_W + K_W;
   localparam int X_W     = PROD2_W - 10;
   localparam int XC_W    = 14;
   localparam int RECIP_W = 13;
   localparam int PROD3_W = XC_W + RECIP_W;
   localparam int RECIP_SHIFT = 19;

   // Sensor gain of 1033/1024.
   localparam logic [GAIN_W-1:0] SENSOR_GAIN = GAIN_W'(1033);

   // Segment factors; the low 48 V segment divides by 1024 only.
   localparam logic [K_W-1:0] K48_LOW  = K_W'(182);
   localparam logic [K_W-1:0] K48_MID  = K_W'(18078);
   localparam logic [K_W-1:0] K48_HIGH = K_W'(18364);
   localparam logic [K_W-1:0] K60_LOW  = K_W'(15098);
   localparam logic [K_W-1:0] K60_MID  = K_W'(15151);
   localparam logic [K_W-1:0] K60_HIGH = K_W'(15110);

   // Segment breaks.
   localparam logic [V_W-1:0] BREAK48_LO = V_W'(210);
   localparam logic [V_W-1:0] BREAK48_HI = V_W'(240);
   localparam logic [V_W-1:0] BREAK60_LO = V_W'(260);
   localparam logic [V_W-1:0] BREAK60_HI = V_W'(300);

   // Divide by 100 through a reciprocal; exact for values up to the clamp point.
   localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(5243);
   localparam logic [X_W-1:0]     X_CLAMP   = X_W'(9900);
   localparam logic [RAW_W-1:0]   RAW_MAX   = RAW_W'(99);

   // Back datapath.
   localparam int NUM_W     = 17;
   localparam int MUL1000_W = 10;
   localparam logic [MUL1000_W-1:0] CAL_GAIN = MUL1000_W'(1000);
   localparam int DIV_STEPS = NUM_W;
   localparam int DCNT_W    = $clog2(DIV_STEPS);
   localparam logic [CAL_W-1:0] CAL_MAX = '1;

   // Queue between front and back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   // Configuration register indexes.
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_VOLTAGE_MODE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_SCALE  = 1'b1;
   localparam logic [SCALE_W-1:0]   SCALE_RESET = SCALE_W'(1000);

   typedef enum logic [2:0] {
      F_IDLE,
      F_ACCUM,
      F_MEAN,
      F_SEG,
      F_RECIP,
      F_PUSH
   } front_state_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_MUL,
      B_DIV,
      B_DONE
   } back_state_type;

   typedef struct packed {
      logic             push;
      logic [RAW_W-1:0] raw;
   } queue_write_type;

   typedef struct packed {
      logic             valid;
      logic [RAW_W-1:0] raw;
   } queue_read_type;

endpackage

`default_nettype wire

// ----- hw/rtl/ssas_front.sv -----
`default_nettype none

module ssas_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          push,
   output logic                               full,
   input  wire logic [ssas_pkg::ADC_W-1:0]    adc_word,
   input  wire logic                          voltage_mode,
   input  wire logic                          q_full,
   output ssas_pkg::queue_write_type          q_wr
);
   import ssas_pkg::*;

   front_state_type state_ff, state_in;

   logic [SAMPLE_W-1:0] ring_ff [AVG_DEPTH];
   logic [AVG_LOG2-1:0] idx_ff;
   logic [SUM_W-1:0]    sum_ff;

   logic [SAMPLE_W-1:0] sample_ff;
   logic [PROD1_W-1:0]  prod1_ff;
   logic [PROD2_W-1:0]  prod2_ff;
   logic [PROD3_W-1:0]  prod3_ff;
   logic                low_seg_ff;
   logic [RAW_W-1:0]    low_raw_ff;

   logic                accept;
   logic [SAMPLE_W-1:0] mean;
   logic [V_W-1:0]      v;
   logic [K_W-1:0]      k_sel;
   logic                low_sel;
   logic [X_W-1:0]      x;
   logic [XC_W-1:0]     xc;
   logic [RAW_W-1:0]    raw_out;

   assign accept = push && !full;
   assign mean   = sum_ff[SUM_W-1:AVG_LOG2];
   assign v      = prod1_ff[PROD1_W-1:10];
   assign x      = prod2_ff[PROD2_W-1:10];
   assign xc     = (x >= X_CLAMP) ? XC_W'(X_CLAMP) : x[XC_W-1:0];
   assign raw_out = low_seg_ff ? low_raw_ff : prod3_ff[RECIP_SHIFT+RAW_W-1:RECIP_SHIFT];

   // Segment factor selection.
   always_comb begin
      low_sel = 1'b0;
      if (!voltage_mode) begin
         if (v < BREAK48_LO) begin
            k_sel   = K48_LOW;
            low_sel = 1'b1;
         end else if (v < BREAK48_HI) begin
            k_sel = K48_MID;
         end else begin
            k_sel = K48_HIGH;
         end
      end else begin
         if (v < BREAK60_LO) begin
            k_sel = K60_LOW;
         end else if (v < BREAK60_HI) begin
            k_sel = K60_MID;
         end else begin
            k_sel = K60_HIGH;
         end
      end
   end

   // Sequencer state register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and queue write.
   always_comb begin
      state_in  = state_ff;
      full      = (state_ff != F_IDLE);
      q_wr.push = 1'b0;
      q_wr.raw  = raw_out;
      unique case (state_ff)
         F_IDLE: begin
            if (push) begin
               state_in = F_ACCUM;
            end
         end
         F_ACCUM: state_in = F_MEAN;
         F_MEAN:  state_in = F_SEG;
         F_SEG:   state_in = F_RECIP;
         F_RECIP: state_in = F_PUSH;
         F_PUSH: begin
            if (!q_full) begin
               q_wr.push = 1'b1;
               state_in  = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   // Sample ring and running sum; the oldest sample leaves as the new one enters.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < AVG_DEPTH; i++) begin
            ring_ff[i] <= '0;
         end
         idx_ff <= '0;
         sum_ff <= '0;
      end else if (state_ff == F_ACCUM) begin
         sum_ff <= sum_ff - SUM_W'(ring_ff[idx_ff]) + SUM_W'(sample_ff);
         ring_ff[idx_ff] <= sample_ff;
         idx_ff <= idx_ff + 1'b1;
      end
   end

   // Scaling datapath, one multiplication per step.
   always_ff @(posedge clock) begin
      if (accept) begin
         sample_ff <= adc_word[ADC_W-1:ADC_W-SAMPLE_W];
      end
      if (state_ff == F_MEAN) begin
         prod1_ff <= PROD1_W'(mean) * PROD1_W'(SENSOR_GAIN);
      end
      if (state_ff == F_SEG) begin
         prod2_ff   <= PROD2_W'(v) * PROD2_W'(k_sel);
         low_seg_ff <= low_sel;
      end
      if (state_ff == F_RECIP) begin
         prod3_ff   <= PROD3_W'(xc) * PROD3_W'(RECIP_100);
         low_raw_ff <= (x > X_W'(RAW_MAX)) ? RAW_MAX : x[RAW_W-1:0];
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/ssas_queue.sv -----
`default_nettype none

module ssas_queue (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire ssas_pkg::queue_write_type q_wr,
   output logic                           q_full,
   output ssas_pkg::queue_read_type       q_rd,
   input  wire logic                      q_pop
);
   import ssas_pkg::*;

   logic [RAW_W-1:0]  entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign q_full   = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_rd.valid = (count_ff != '0);
   assign q_rd.raw   = entry_ff[rd_ptr_ff];
   assign do_push  = q_wr.push && !q_full;
   assign do_pop   = q_pop && q_rd.valid;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = do_push ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= q_wr.raw;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/ssas_back.sv -----
`default_nettype none

module ssas_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire ssas_pkg::queue_read_type      q_rd,
   output logic                               q_pop,
   input  wire logic [ssas_pkg::SCALE_W-1:0]  speed_scale,
   output logic                               empty,
   input  wire logic                          pop,
   output logic [ssas_pkg::RAW_W-1:0]         raw_speed,
   output logic [ssas_pkg::CAL_W-1:0]         calibrated_speed
);
   import ssas_pkg::*;

   back_state_type state_ff, state_in;

   logic [RAW_W-1:0]   raw_ff;
   logic [NUM_W-1:0]   num_ff;
   logic [SCALE_W-1:0] rem_ff;
   logic [DCNT_W-1:0]  cnt_ff;
   logic               out_valid_ff, out_valid_in;
   logic [RAW_W-1:0]   out_raw_ff;
   logic [CAL_W-1:0]   out_cal_ff;

   logic               out_load;
   logic [SCALE_W:0]   trial;
   logic               ge;
   logic [SCALE_W-1:0] rem_next;
   logic [CAL_W-1:0]   cal_sat;

   // One restoring division step: shift in the next numerator bit and try to subtract.
   assign trial    = {rem_ff, num_ff[NUM_W-1]};
   assign ge       = (trial >= {1'b0, speed_scale});
   assign rem_next = ge ? SCALE_W'(trial - {1'b0, speed_scale}) : trial[SCALE_W-1:0];
   assign cal_sat  = (|num_ff[NUM_W-1:CAL_W]) ? CAL_MAX : num_ff[CAL_W-1:0];

   assign empty            = !out_valid_ff;
   assign raw_speed        = out_raw_ff;
   assign calibrated_speed = out_cal_ff;

   // Sequencer state register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Next state, queue pop and output register load.
   always_comb begin
      state_in = state_ff;
      q_pop    = 1'b0;
      out_load = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            if (q_rd.valid) begin
               q_pop    = 1'b1;
               state_in = B_MUL;
            end
         end
         B_MUL: state_in = B_DIV;
         B_DIV: begin
            if (cnt_ff == DCNT_W'(DIV_STEPS - 1)) begin
               state_in = B_DONE;
            end
         end
         B_DONE: begin
            if (!out_valid_ff || pop) begin
               out_load = 1'b1;
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
      out_valid_in = out_load ? 1'b1 : (pop ? 1'b0 : out_valid_ff);
   end

   // Multiply by 1000, then divide by the scale one quotient bit per cycle.
   always_ff @(posedge clock) begin
      if (q_pop) begin
         raw_ff <= q_rd.raw;
      end
      if (state_ff == B_MUL) begin
         num_ff <= NUM_W'(raw_ff) * NUM_W'(CAL_GAIN);
         rem_ff <= '0;
         cnt_ff <= '0;
      end
      if (state_ff == B_DIV) begin
         num_ff <= {num_ff[NUM_W-2:0], ge};
         rem_ff <= rem_next;
         cnt_ff <= cnt_ff + 1'b1;
      end
      if (out_load) begin
         out_raw_ff <= raw_ff;
         out_cal_ff <= cal_sat;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/speed_sensor_average_and_scale_core.sv -----
// Channel    Direction  Handshake                      Payload
// input      in         push / full                    req_adc_word
// result     out        empty / pop                    rsp_raw_speed, rsp_calibrated_speed
// csr        in         csr_write_enable, csr_index    csr_write_data
//
// Each transaction passes from acceptance to result through the front sequencer
// (ring update, three multiplies, queue write) and then the back end (pop, multiply,
// 17 one-bit division steps, result load); each side finishes one before taking the next.
// Synchronous reset clears the sample ring, running sum and queue, and presets both CSRs.
// A two-entry queue between front and back lets either side stall independently; a
// waiting result holds the back end, and once the queue fills, the input stalls too.
`default_nettype none
`include "speed_sensor_average_and_scale_core_assert.svh"

module speed_sensor_average_and_scale_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            push,
   output logic                                 full,
   input  wire logic [ssas_pkg::ADC_W-1:0]      req_adc_word,
   output logic                                 empty,
   input  wire logic                            pop,
   output logic [ssas_pkg::RAW_W-1:0]           rsp_raw_speed,
   output logic [ssas_pkg::CAL_W-1:0]           rsp_calibrated_speed,
   input  wire logic                            csr_write_enable,
   input  wire logic [ssas_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [ssas_pkg::SCALE_W-1:0]    csr_write_data
);
   import ssas_pkg::*;

   logic               voltage_mode_ff;
   logic [SCALE_W-1:0] speed_scale_ff;

   queue_write_type q_wr;
   queue_read_type  q_rd;
   logic            q_full;
   logic            q_pop;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         voltage_mode_ff <= 1'b1;
         speed_scale_ff  <= SCALE_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_VOLTAGE_MODE: voltage_mode_ff <= csr_write_data[0];
            CSR_SPEED_SCALE:  speed_scale_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Front end: averaging and raw speed.
   ssas_front u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .full         (full),
      .adc_word     (req_adc_word),
      .voltage_mode (voltage_mode_ff),
      .q_full       (q_full),
      .q_wr         (q_wr)
   );

   // Queue between front and back.
   ssas_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_wr   (q_wr),
      .q_full (q_full),
      .q_rd   (q_rd),
      .q_pop  (q_pop)
   );

   // Back end: calibration divide and result register.
   ssas_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_rd             (q_rd),
      .q_pop            (q_pop),
      .speed_scale      (speed_scale_ff),
      .empty            (empty),
      .pop              (pop),
      .raw_speed        (rsp_raw_speed),
      .calibrated_speed (rsp_calibrated_speed)
   );

   // Checks on the internal handoffs.
   `SSAS_ASSERT_IMPLY(a_raw_range, !empty, rsp_raw_speed <= RAW_MAX, "raw speed above clamp")
   `SSAS_ASSERT_IMPLY(a_no_overflow, q_wr.push, !q_full, "push into full queue")
   `SSAS_ASSERT_IMPLY(a_no_underflow, q_pop, q_rd.valid, "pop from empty queue")
   `SSAS_ASSERT_NEXT(a_busy_after_accept, push && !full, full, "front not busy after accept")

endmodule

`default_nettype wire
